>>> hw/rtl/hdum_pkg.sv
// ---------------------------------------------------------------------------
// HID descriptor usage matcher package
// Shared payload types, item tag codes and configuration register indexes.
// ---------------------------------------------------------------------------
package hdum_pkg;

    typedef struct packed {
        logic [7:0] descriptor_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        is_match;
        logic [31:0] usage_page_seen;
        logic [31:0] usage_seen;
    } t_out_item;

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_USAGE_PAGE = 1'b0,
        CFG_TARGET_USAGE      = 1'b1
    } t_cfg_index;

    localparam logic [31:0] TARGET_USAGE_PAGE_RST = 32'h0000_FF43;
    localparam logic [31:0] TARGET_USAGE_RST      = 32'h0000_0602;

    localparam logic [7:0] SIZE_MASK          = 8'h03;
    localparam logic [7:0] TAG_MASK           = 8'hFC;
    localparam logic [7:0] TAG_USAGE_PAGE     = 8'h04;
    localparam logic [7:0] TAG_USAGE          = 8'h08;
    localparam logic [7:0] TAG_COLLECTION     = 8'hA0;
    localparam logic [7:0] TAG_END_COLLECTION = 8'hC0;

    localparam logic [1:0] SIZE_CODE_NONE = 2'd0;
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
    localparam logic [2:0] FOUR_BYTES     = 3'd4;
    localparam logic [7:0] DEPTH_MAX      = 8'd255;

endpackage

>>> hw/rtl/hdum_in_stage.sv
// ---------------------------------------------------------------------------
// HID descriptor usage matcher input stage
// Registers one input transfer and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module hdum_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hdum_pkg::t_in_item i_data,
    output logic              o_item_valid,
    output hdum_pkg::t_in_item o_item,
    input  logic              i_take
);
    import hdum_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_data;

    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

>>> hw/rtl/hdum_parser.sv
// ---------------------------------------------------------------------------
// HID descriptor usage matcher parser
// Short item parser state, target registers and top-level usage matching.
// ---------------------------------------------------------------------------
module hdum_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [hdum_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_wr_data,
    input  logic                           i_step,
    input  hdum_pkg::t_in_item             i_item,
    output logic                           o_res_valid,
    output hdum_pkg::t_out_item            o_res
);
    import hdum_pkg::*;

    logic [31:0] r_target_page;
    logic [31:0] r_target_usage;

    logic [7:0]  r_tag,   n_tag;
    logic [2:0]  r_left,  n_left;
    logic [1:0]  r_pos,   n_pos;
    logic [31:0] r_acc,   n_acc;
    logic [7:0]  r_depth, n_depth;
    logic [31:0] r_page,  n_page;
    logic [31:0] r_usage, n_usage;
    logic        r_have_page,  n_have_page;
    logic        r_have_usage, n_have_usage;
    logic        r_found,      n_found;

    logic        apply;
    logic [7:0]  tag_w;
    logic [31:0] val_w;
    logic [7:0]  b;

    assign b = i_item.descriptor_byte;

    always_comb begin
        n_tag        = r_tag;
        n_left       = r_left;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_depth      = r_depth;
        n_page       = r_page;
        n_usage      = r_usage;
        n_have_page  = r_have_page;
        n_have_usage = r_have_usage;
        n_found      = r_found;
        apply        = 1'b0;
        tag_w        = r_tag;
        val_w        = r_acc;

        if (i_step && !r_found) begin
            if (r_left == 3'd0) begin
                n_tag = b;
                n_pos = 2'd0;
                n_acc = 32'd0;
                if ((b & SIZE_MASK) == {6'd0, SIZE_CODE_FOUR}) begin
                    n_left = FOUR_BYTES;
                end else begin
                    n_left = {1'b0, b[1:0]};
                end
                apply = ((b & SIZE_MASK) == {6'd0, SIZE_CODE_NONE});
                tag_w = b;
                val_w = 32'd0;
            end else begin
                val_w  = r_acc | ({24'd0, b} << {r_pos, 3'b000});
                n_acc  = val_w;
                n_pos  = r_pos + 2'd1;
                n_left = r_left - 3'd1;
                apply  = (r_left == 3'd1);
                tag_w  = r_tag;
            end
        end

        if (apply) begin
            unique case (tag_w & TAG_MASK)
                TAG_USAGE_PAGE: begin
                    if (r_depth == 8'd0) begin
                        n_page       = val_w;
                        n_have_page  = 1'b1;
                        n_have_usage = 1'b0;
                        n_usage      = 32'd0;
                    end
                end
                TAG_USAGE: begin
                    if (r_depth == 8'd0 && !r_have_usage) begin
                        n_usage      = val_w;
                        n_have_usage = 1'b1;
                    end
                end
                TAG_COLLECTION: begin
                    if (r_depth == 8'd0 && r_have_page && r_have_usage) begin
                        if (r_page == r_target_page && r_usage == r_target_usage) begin
                            n_found = 1'b1;
                        end else begin
                            n_have_usage = 1'b0;
                            n_usage      = 32'd0;
                        end
                    end
                    if (r_depth != DEPTH_MAX) begin
                        n_depth = r_depth + 8'd1;
                    end
                end
                TAG_END_COLLECTION: begin
                    if (r_depth != 8'd0) begin
                        n_depth = r_depth - 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        o_res_valid           = i_step && i_item.last_byte;
        o_res.is_match        = n_found;
        o_res.usage_page_seen = n_page;
        o_res.usage_seen      = n_usage;

        if (o_res_valid) begin
            n_tag        = 8'd0;
            n_left       = 3'd0;
            n_pos        = 2'd0;
            n_acc        = 32'd0;
            n_depth      = 8'd0;
            n_page       = 32'd0;
            n_usage      = 32'd0;
            n_have_page  = 1'b0;
            n_have_usage = 1'b0;
            n_found      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_page  <= TARGET_USAGE_PAGE_RST;
            r_target_usage <= TARGET_USAGE_RST;
            r_tag          <= 8'd0;
            r_left         <= 3'd0;
            r_pos          <= 2'd0;
            r_acc          <= 32'd0;
            r_depth        <= 8'd0;
            r_page         <= 32'd0;
            r_usage        <= 32'd0;
            r_have_page    <= 1'b0;
            r_have_usage   <= 1'b0;
            r_found        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_TARGET_USAGE_PAGE: r_target_page  <= i_cfg_wr_data;
                    CFG_TARGET_USAGE:      r_target_usage <= i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            r_tag        <= n_tag;
            r_left       <= n_left;
            r_pos        <= n_pos;
            r_acc        <= n_acc;
            r_depth      <= n_depth;
            r_page       <= n_page;
            r_usage      <= n_usage;
            r_have_page  <= n_have_page;
            r_have_usage <= n_have_usage;
            r_found      <= n_found;
        end
    end

endmodule

>>> hw/rtl/hdum_out_stage.sv
// ---------------------------------------------------------------------------
// HID descriptor usage matcher output stage
// Result register that holds a finished result until the consumer takes it.
// ---------------------------------------------------------------------------
module hdum_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hdum_pkg::t_out_item i_res,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output hdum_pkg::t_out_item o_data
);
    import hdum_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

endmodule

>>> hw/rtl/hid_descriptor_usage_matcher.sv
// ---------------------------------------------------------------------------
// HID descriptor usage matcher
// Parses a HID report descriptor one byte per transfer and reports whether a
// top-level collection carries the configured usage page and usage.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//   cfg       input      i_cfg_wr_en                i_cfg_index, i_cfg_wr_data
//
// One byte is accepted per cycle while the input register is free or taken.
// A byte is parsed when the parser takes it from the input register, and the
// result for a last byte is loaded into the result register as it is parsed.
// A last byte waits in the input register while the result register is full
// and not being drained; other bytes never wait.
// Reset is synchronous and restores the targets to their defaults.
// ---------------------------------------------------------------------------
module hid_descriptor_usage_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hdum_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hdum_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_wr_en,
    input  logic [hdum_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_wr_data
);
    import hdum_pkg::*;

    logic      item_valid;
    t_in_item  item;
    logic      take;
    logic      out_free;
    logic      res_valid;
    t_out_item res;

    assign take = item_valid && (!item.last_byte || out_free);

    hdum_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data       (i_in_data),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    hdum_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (take),
        .i_item        (item),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    hdum_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
